FILE: rtl/dds_ramp_step_calculator_defines.svh
// ----------------------------------------------------------------------------
// DDS ramp step calculator assertion macros
// Shared concurrent assertion forms for the ramp step calculator.
// ----------------------------------------------------------------------------
`ifndef DDS_RAMP_STEP_CALCULATOR_DEFINES_SVH
`define DDS_RAMP_STEP_CALCULATOR_DEFINES_SVH

// same-cycle implication
`define DRSC_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("implication check failed");

// next-cycle implication
`define DRSC_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("next-cycle check failed");

`endif

FILE: rtl/drsc_pkg.sv
// ----------------------------------------------------------------------------
// drsc_pkg
// Types and constants of the DDS ramp step calculator.
// ----------------------------------------------------------------------------
package drsc_pkg;

  localparam int unsigned DIV1_STEPS = 30;
  localparam int unsigned DIV2_STEPS = 32;

  localparam logic [29:0] NS_PER_SEC  = 30'd1000000000;
  localparam logic [29:0] CLK_RESET   = 30'd1000000000;
  localparam logic [29:0] TSTEP_RESET = 30'd4;
  localparam logic [29:0] MIN_CLK     = 30'd4;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_TIME = 2'd1,
    ST_ZERO_DIFF = 2'd2,
    ST_SAT       = 2'd3
  } status_t;

  typedef struct packed {
    logic        valid;
    status_t     st;
    logic [61:0] p;
    logic [61:0] b;
    logic        use_div;
    logic [29:0] r;
    logic [29:0] q;
  } d1_t;

  typedef struct packed {
    logic        valid;
    status_t     st;
    logic [61:0] p;
    logic [61:0] b;
    logic        use_div;
    logic [31:0] mult;
  } m_t;

  typedef struct packed {
    logic        valid;
    status_t     st;
    logic [61:0] b;
    logic [61:0] r;
    logic [31:0] q;
    logic [31:0] mult;
    logic        ovf;
  } d2_t;

endpackage

FILE: rtl/dds_ramp_step_calculator.sv
// ----------------------------------------------------------------------------
// dds_ramp_step_calculator
// Sweep step word and step time multiplier for a DDS frequency ramp.
// ----------------------------------------------------------------------------
// One result per request, one request per cycle while not busy and not
// stalled at the output. The multiplier and step word divisions are each
// a chain of one restoring step per pipeline stage. A system_clock_hz write
// starts a serial division for the base step time; input is stalled then.
`include "dds_ramp_step_calculator_defines.svh"

module dds_ramp_step_calculator
  import drsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [29:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] start_freq_hz,
  input  logic [31:0] stop_freq_hz,
  input  logic [31:0] ramp_time_ns,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] freq_step_word,
  output logic [31:0] step_time_multiplier,
  output logic [1:0]  status
);

  // base step time unit
  logic [29:0] sclk;
  logic [29:0] tstep;
  logic        busy;
  logic [4:0]  cnt;
  logic [27:0] dr;
  logic [28:0] dq;
  logic [27:0] dden;
  logic [28:0] t_sh;
  logic        t_ge;

  assign t_sh = {dr, NS_PER_SEC[cnt]};
  assign t_ge = t_sh >= {1'b0, dden};

  always_ff @(posedge clk) begin
    if (rst) begin
      sclk  <= CLK_RESET;
      tstep <= TSTEP_RESET;
      busy  <= 1'b0;
      cnt   <= '0;
    end else if (cfg_we) begin
      sclk <= cfg_wdata;
      busy <= 1'b1;
      cnt  <= 5'(DIV1_STEPS - 1);
      dr   <= '0;
      dq   <= '0;
      dden <= (cfg_wdata < MIN_CLK) ? 28'd1 : cfg_wdata[29:2];
    end else if (busy) begin
      dr <= t_ge ? 28'(t_sh - {1'b0, dden}) : t_sh[27:0];
      dq <= {dq[27:0], t_ge};
      if (cnt == 5'd0) begin
        busy  <= 1'b0;
        tstep <= {dq, t_ge};
      end else begin
        cnt <= cnt - 5'd1;
      end
    end
  end

  logic        adv;
  logic        acc;
  logic [29:0] s_eff;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = busy || !adv;
  assign acc      = in_valid && !in_stall;
  assign s_eff    = (sclk < MIN_CLK) ? MIN_CLK : sclk;

  // stage A: difference and flags
  logic        a_valid;
  status_t     a_st;
  logic [31:0] a_d;
  logic [31:0] a_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_d <= (stop_freq_hz >= start_freq_hz) ? stop_freq_hz - start_freq_hz
                                             : start_freq_hz - stop_freq_hz;
      a_t <= ramp_time_ns;
      if (ramp_time_ns == 32'd0) begin
        a_st <= ST_ZERO_TIME;
      end else if (stop_freq_hz == start_freq_hz) begin
        a_st <= ST_ZERO_DIFF;
      end else begin
        a_st <= ST_OK;
      end
    end
  end

  // stage B: products
  logic        b_valid;
  status_t     b_st;
  logic [61:0] b_p;
  logic [61:0] b_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_st <= a_st;
      b_p  <= 62'(a_d) * 62'(tstep);
      b_b  <= 62'(s_eff) * 62'(a_t);
    end
  end

  // multiplier division: floor((b >> 32) / p), one bit per stage
  d1_t d1 [DIV1_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      d1[0].valid <= 1'b0;
    end else if (adv) begin
      d1[0].valid   <= b_valid;
      d1[0].st      <= b_st;
      d1[0].p       <= b_p;
      d1[0].b       <= b_b;
      d1[0].use_div <= (b_p < {32'd0, b_b[61:32]})
                    || ((b_p == {32'd0, b_b[61:32]}) && (b_b[31:0] != 32'd0));
      d1[0].r       <= '0;
      d1[0].q       <= '0;
    end
  end

  for (genvar k = 0; k < DIV1_STEPS; k++) begin : g_div1
    logic [30:0] sh;
    logic        ge;
    d1_t         nx;
    assign sh = {d1[k].r, d1[k].b[61-k]};
    assign ge = d1[k].use_div && (sh >= {1'b0, d1[k].p[29:0]});
    always_comb begin
      nx   = d1[k];
      nx.r = ge ? 30'(sh - {1'b0, d1[k].p[29:0]}) : sh[29:0];
      nx.q = {d1[k].q[28:0], ge};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        d1[k+1].valid <= 1'b0;
      end else if (adv) begin
        d1[k+1] <= nx;
      end
    end
  end

  // multiplier rounding
  m_t          mr;
  d1_t         dl;
  logic        rnd1;

  assign dl   = d1[DIV1_STEPS];
  assign rnd1 = {dl.r, dl.b[31]} >= {1'b0, dl.p[29:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      mr.valid <= 1'b0;
    end else if (adv) begin
      mr.valid   <= dl.valid;
      mr.st      <= dl.st;
      mr.p       <= dl.p;
      mr.b       <= dl.b;
      mr.use_div <= dl.use_div;
      mr.mult    <= dl.use_div ? (32'(dl.q) + 32'(rnd1)) : 32'd1;
    end
  end

  // scaled product
  logic        e_valid;
  status_t     e_st;
  logic [61:0] e_big;
  logic [61:0] e_b;
  logic [31:0] e_mult;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (adv) begin
      e_valid <= mr.valid;
      e_st    <= mr.st;
      e_b     <= mr.b;
      e_mult  <= mr.mult;
      e_big   <= mr.use_div ? 62'(mr.p[29:0]) * 62'(mr.mult[30:0]) : mr.p;
    end
  end

  // step word division: floor(big * 2^32 / b), one bit per stage
  d2_t d2 [DIV2_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      d2[0].valid <= 1'b0;
    end else if (adv) begin
      d2[0].valid <= e_valid;
      d2[0].st    <= e_st;
      d2[0].b     <= e_b;
      d2[0].r     <= e_big;
      d2[0].q     <= '0;
      d2[0].mult  <= e_mult;
      d2[0].ovf   <= e_big >= e_b;
    end
  end

  for (genvar k = 0; k < DIV2_STEPS; k++) begin : g_div2
    logic [62:0] sh;
    logic        ge;
    d2_t         nx;
    assign sh = {d2[k].r, 1'b0};
    assign ge = sh >= {1'b0, d2[k].b};
    always_comb begin
      nx   = d2[k];
      nx.r = ge ? 62'(sh - {1'b0, d2[k].b}) : sh[61:0];
      nx.q = {d2[k].q[30:0], ge};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        d2[k+1].valid <= 1'b0;
      end else if (adv) begin
        d2[k+1] <= nx;
      end
    end
  end

  // final rounding, saturation and output register
  d2_t  fl;
  logic rnd2;
  logic sat;

  assign fl   = d2[DIV2_STEPS];
  assign rnd2 = {fl.r, 1'b0} >= {1'b0, fl.b};
  assign sat  = fl.ovf || (rnd2 && (fl.q == 32'hFFFF_FFFF));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= fl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (fl.st != ST_OK) begin
        freq_step_word       <= '0;
        step_time_multiplier <= '0;
        status               <= fl.st;
      end else if (sat) begin
        freq_step_word       <= 32'hFFFF_FFFF;
        step_time_multiplier <= fl.mult;
        status               <= ST_SAT;
      end else begin
        freq_step_word       <= fl.q + 32'(rnd2);
        step_time_multiplier <= fl.mult;
        status               <= ST_OK;
      end
    end
  end

  `DRSC_ASSERT_IMP(a_zero_time, out_valid && (status == ST_ZERO_TIME), !(|{freq_step_word, step_time_multiplier}))
  `DRSC_ASSERT_IMP(a_sat_word, out_valid && (status == ST_SAT), freq_step_word == 32'hFFFF_FFFF)
  `DRSC_ASSERT_IMP(a_busy_stall, busy, in_stall)
  `DRSC_ASSERT_NXT(a_cfg_busy, cfg_we, busy)

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Ramp step calculator test: directed and random ramp requests under varying
// sender/receiver idling and several system clock settings, each result
// checked against an exact-integer prediction of step word and multiplier.
// ----------------------------------------------------------------------------
module tb_top
  import drsc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] ftw;
    logic [31:0] mult;
    status_t     st;
  } ramp_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [29:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] start_freq_hz = '0;
  logic [31:0] stop_freq_hz = '0;
  logic [31:0] ramp_time_ns = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] freq_step_word;
  logic [31:0] step_time_multiplier;
  logic [1:0]  status;

  logic [29:0] sys_clk_hz;
  ramp_res_t   expected_q[$];
  int          errors = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  always #1 clk = ~clk;

  dds_ramp_step_calculator u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .start_freq_hz(start_freq_hz),
    .stop_freq_hz(stop_freq_hz), .ramp_time_ns(ramp_time_ns),
    .out_valid(out_valid), .out_stall(out_stall),
    .freq_step_word(freq_step_word), .step_time_multiplier(step_time_multiplier),
    .status(status)
  );

  function automatic ramp_res_t calc_ramp_step(logic [31:0] f1, logic [31:0] f2,
                                               logic [31:0] t);
    ramp_res_t   res;
    logic [63:0] s, tstep, d, p, b, a, mult, big, rem;
    logic [95:0] num, q;
    s = (sys_clk_hz < 4) ? 64'd4 : 64'(sys_clk_hz);
    tstep = 64'd1000000000 / (s / 4);
    d = (f2 >= f1) ? 64'(f2 - f1) : 64'(f1 - f2);
    res.ftw = '0;
    res.mult = '0;
    if (t == 0) begin
      res.st = ST_ZERO_TIME;
      return res;
    end
    if (d == 0) begin
      res.st = ST_ZERO_DIFF;
      return res;
    end
    p = d * tstep;
    b = s * 64'(t);
    mult = 1;
    if (p < (64'd1 << 30)) begin
      a = p << 32;
      if (a < b) begin
        mult = b / a;
        rem = b % a;
        if (rem >= a - rem) mult = mult + 1;
      end
    end
    big = p * mult;
    res.mult = mult[31:0];
    num = {big, 32'd0};
    q = num / 96'(b);
    if ((num % 96'(b)) * 2 >= 96'(b)) q = q + 1;
    if (big >= b || q > 96'hFFFFFFFF) begin
      res.ftw = 32'hFFFFFFFF;
      res.st = ST_SAT;
    end else begin
      res.ftw = q[31:0];
      res.st = ST_OK;
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp);
    $display("MISMATCH %s: got %0d expected %0d", what, got, exp);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    ramp_res_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected transfer", 32'd0, 32'd0);
      end else begin
        e = expected_q.pop_front();
        if (freq_step_word !== e.ftw) report_mismatch("freq_step_word", freq_step_word, e.ftw);
        if (step_time_multiplier !== e.mult)
          report_mismatch("step_time_multiplier", step_time_multiplier, e.mult);
        if (status !== e.st) report_mismatch("status", 32'(status), 32'(e.st));
      end
    end
  end

  always @(negedge clk) begin
    if (!rst) out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // entered at a falling edge; leaves valid high after the transfer so the
  // next call or drain decides the next value
  task automatic send_ramp(logic [31:0] f1, logic [31:0] f2, logic [31:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    start_freq_hz <= f1;
    stop_freq_hz <= f2;
    ramp_time_ns <= t;
    expected_q.push_back(calc_ramp_step(f1, f2, t));
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_sys_clk(logic [29:0] hz);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= hz;
    sys_clk_hz = hz;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(3))
      0: return $urandom_range(1000);
      1: return $urandom & 32'h00FF_FFFF;
      2: return 32'hFFFF_FFFF - $urandom_range(1000);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed;
    send_ramp(0, 0, 0);
    send_ramp(32'hFFFFFFFF, 0, 0);
    send_ramp(5, 5, 1000);
    send_ramp(0, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_ramp(32'hFFFFFFFF, 0, 1);
    send_ramp(0, 1, 32'hFFFFFFFF);
    send_ramp(1, 0, 32'hFFFFFFFF);
    send_ramp(1000000, 2000000, 1000000);
    send_ramp(2000000, 1000000, 1000000);
    send_ramp(0, 100, 1);
    send_ramp(0, 32'hFFFFFFFF, 1);
    send_ramp(32'hAAAAAAAA, 32'h55555555, 32'h5555AAAA);
    send_ramp(32'h55555555, 32'hAAAAAAAA, 32'hAAAA5555);
  endtask

  task automatic test_random(int n);
    logic [31:0] f1;
    for (int i = 0; i < n; i++) begin
      f1 = rand_word();
      case ($urandom_range(9))
        0: send_ramp(f1, f1, rand_word());
        1: send_ramp(f1, rand_word(), 0);
        default: send_ramp(f1, rand_word(), rand_word());
      endcase
    end
  endtask

  task automatic test_clock_settings;
    logic [29:0] clks[6] = '{30'd1000000000, 30'd0, 30'd3, 30'd4, 30'h3FFFFFFF,
                             30'd12345678};
    foreach (clks[i]) begin
      write_sys_clk(clks[i]);
      test_directed();
      test_random(20);
    end
  endtask

  initial begin
    sys_clk_hz = CLK_RESET;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_idle_pct = 36; recv_idle_pct = 65;
    test_directed();
    test_random(150);
    send_idle_pct = 65; recv_idle_pct = 36;
    test_clock_settings();
    send_idle_pct = 0; recv_idle_pct = 0;
    write_sys_clk(30'($urandom_range(30'h3FFFFFFF, 4)));
    test_random(150);
    write_sys_clk(30'd500000000);
    test_random(100);
    drain();
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+rtl
rtl/drsc_pkg.sv
rtl/dds_ramp_step_calculator.sv
tb/sv/tb_top.sv
